/* sv/dhsi_pkg.sv */
// Shared types and constants for the double-hashing key table.
package dhsi_pkg;

	localparam int KEY_W    = 64;
	localparam int SIZE_W   = 11;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 3;
	localparam int DIV_BITS = 4;                    // dividend bits retired per cycle
	localparam int DIV_CNT_W = $clog2(KEY_W / DIV_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

	// Operation codes on the input tuser
	localparam logic OP_SEARCH = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Job kind decided by the front end
	typedef enum logic [1:0] {
		K_SEARCH,
		K_CLEAR,
		K_ZERO,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [KEY_W-1:0]   key;
		logic [SIZE_W-1:0]  pos;   // start slot
		logic [SIZE_W-1:0]  inc;   // probe step
		logic [SIZE_W-1:0]  size;
	} job_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_CLEAR,
		B_RD,
		B_CMP
	} back_state_t;

endpackage

/* sv/dhsi_fifo.sv */
// Short job queue between the front end and the back end.
module dhsi_fifo
	import dhsi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctl_t  ctl,
	input  job_t    wr_job,
	output job_t    rd_job,
	output q_stat_t stat
);

	job_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign stat = '{full:  (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH)),
	                empty: (cnt_q == '0)};
	assign rd_job     = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!ctl.push && ctl.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/dhsi_front.sv */
// Front end: takes input transfers, classifies them and computes both hash remainders.
module dhsi_front
	import dhsi_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	input  logic [KEY_W-1:0]  in_key,
	input  logic [SIZE_W-1:0] table_size,
	input  logic              hold,       // reset sweep still running
	input  logic              q_full,
	output logic              q_push,
	output job_t              q_job
);

	front_state_t          state_q, state_nx;
	kind_t                 kind_q;
	logic [KEY_W-1:0]      key_q;
	logic [KEY_W-1:0]      code_q;
	logic [SIZE_W-1:0]     size_q;
	logic [SIZE_W-1:0]     rem_a_q, rem_b_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [SIZE_W-1:0]     rem_a_nx, rem_b_nx;
	logic [SIZE_W-1:0]     div_b;
	logic                  accept;
	kind_t                 kind_in;
	logic                  size_bad;

	assign accept   = in_valid && in_ready;
	assign div_b    = size_q - 1'b1;
	assign size_bad = (table_size < SIZE_MIN) || (32'(table_size) > 32'(STORE_DEPTH));

	// Classify the incoming item
	always_comb begin
		if (in_op == OP_CLEAR) begin
			kind_in = K_CLEAR;
		end else if (in_key == '0) begin
			kind_in = K_ZERO;
		end else if (size_bad) begin
			kind_in = K_BAD;
		end else begin
			kind_in = K_SEARCH;
		end
	end

	// Radix-16 restoring remainder, both divisors side by side
	always_comb begin
		logic [SIZE_W:0]   ta, tb;
		logic [SIZE_W-1:0] ra, rb;
		ra = rem_a_q;
		rb = rem_b_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			ta = {ra, code_q[KEY_W-1-i]};
			tb = {rb, code_q[KEY_W-1-i]};
			if (ta >= {1'b0, size_q}) begin
				ta = ta - {1'b0, size_q};
			end
			if (tb >= {1'b0, div_b}) begin
				tb = tb - {1'b0, div_b};
			end
			ra = ta[SIZE_W-1:0];
			rb = tb[SIZE_W-1:0];
		end
		rem_a_nx = ra;
		rem_b_nx = rb;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_nx = (kind_in == K_SEARCH) ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (div_cnt_q == '1) begin
					state_nx = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_nx = F_IDLE;
				end
			end
			default: state_nx = F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = (state_q == F_IDLE) && !hold;
		q_push     = (state_q == F_PUSH) && !q_full;
		q_job.kind = kind_q;
		q_job.key  = key_q;
		q_job.pos  = rem_a_q;
		q_job.inc  = rem_b_q + 1'b1;
		q_job.size = size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == F_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Item registers and remainder datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_in;
			key_q   <= in_key;
			code_q  <= in_key - 1'b1;
			size_q  <= table_size;
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else if (state_q == F_DIV) begin
			code_q  <= code_q << DIV_BITS;
			rem_a_q <= rem_a_nx;
			rem_b_q <= rem_b_nx;
		end
	end

endmodule

/* sv/dhsi_back.sv */
// Back end: key store, probe sequencer, clearing sweeps and result register.
module dhsi_back
	import dhsi_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  job_t                q_job,
	output logic                init_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SLOT_W-1:0]   out_slot,
	output logic [STATUS_W-1:0] out_status
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

	logic [KEY_W-1:0]    mem [STORE_DEPTH];
	logic [KEY_W-1:0]    rdata_q;

	back_state_t         state_q, state_nx;
	logic [KEY_W-1:0]    key_q;
	logic [SIZE_W-1:0]   pos_q, inc_q, size_q, cnt_q;
	logic [AW-1:0]       sweep_q;
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_W-1:0]    mem_wdata;
	logic [AW-1:0]       rd_addr;
	logic                emit;
	logic [SLOT_W-1:0]   emit_slot;
	logic [STATUS_W-1:0] emit_status;
	logic [SIZE_W:0]     pos_sum;
	logic [SIZE_W-1:0]   pos_next;
	logic                hit_empty, hit_key, last_probe, sweep_end;

	assign rd_addr    = AW'(pos_q);
	assign hit_empty  = (rdata_q == '0);
	assign hit_key    = (rdata_q == key_q);
	assign last_probe = ((cnt_q + 1'b1) == size_q);
	assign sweep_end  = (sweep_q == LAST_ADDR);

	// Next probe slot, wrapped to the table size
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, inc_q};
		if (pos_sum >= {1'b0, size_q}) begin
			pos_sum = pos_sum - {1'b0, size_q};
		end
		pos_next = pos_sum[SIZE_W-1:0];
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_INIT: begin
				if (sweep_end) begin
					state_nx = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty && !out_valid_q) begin
					case (q_job.kind)
						K_CLEAR:  state_nx = B_CLEAR;
						K_SEARCH: state_nx = B_RD;
						default:  state_nx = B_IDLE;
					endcase
				end
			end
			B_CLEAR: begin
				if (sweep_end) begin
					state_nx = B_IDLE;
				end
			end
			B_RD: state_nx = B_CMP;
			B_CMP: begin
				if (hit_empty || hit_key || last_probe) begin
					state_nx = B_IDLE;
				end else begin
					state_nx = B_RD;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop       = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = sweep_q;
		mem_wdata   = '0;
		emit        = 1'b0;
		emit_slot   = '0;
		emit_status = ST_FULL;
		case (state_q)
			B_INIT: begin
				mem_we = 1'b1;
			end
			B_IDLE: begin
				if (!q_empty && !out_valid_q) begin
					q_pop = 1'b1;
					case (q_job.kind)
						K_ZERO: begin
							emit        = 1'b1;
							emit_status = ST_ZERO_KEY;
						end
						K_BAD: begin
							emit        = 1'b1;
							emit_status = ST_FULL;
						end
						default: ;
					endcase
				end
			end
			B_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_end) begin
					emit        = 1'b1;
					emit_status = ST_CLEARED;
				end
			end
			B_CMP: begin
				if (hit_empty) begin
					mem_we      = 1'b1;
					mem_waddr   = rd_addr;
					mem_wdata   = key_q;
					emit        = 1'b1;
					emit_slot   = pos_q[SLOT_W-1:0];
					emit_status = ST_INSERTED;
				end else if (hit_key) begin
					emit        = 1'b1;
					emit_slot   = pos_q[SLOT_W-1:0];
					emit_status = ST_FOUND;
				end else if (last_probe) begin
					emit        = 1'b1;
					emit_status = ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// Key store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// Job registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_q  <= q_job.key;
			pos_q  <= q_job.pos;
			inc_q  <= q_job.inc;
			size_q <= q_job.size;
			cnt_q  <= '0;
		end else if (state_q == B_CMP) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit) begin
			out_slot_q   <= emit_slot;
			out_status_q <= emit_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == B_INIT || state_q == B_CLEAR) begin
				sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign init_busy  = (state_q == B_INIT);
	assign out_valid  = out_valid_q;
	assign out_slot   = out_slot_q;
	assign out_status = out_status_q;

endmodule

/* sv/double_hash_search_insert_core.sv */
// Top level of the double-hashing search-and-insert key table.
// After reset the block sweeps its key store to zero and holds s_tready low meanwhile.
// A search item is accepted, then a radix-16 remainder unit in the front end retires four
// key bits per cycle to form the start slot and the probe step, and the job is pushed
// into the queue once the queue has room. The back end picks up the job, then each probe
// is a registered store read followed by a compare; it picks up no new job while a
// result waits. A clear item sweeps the whole store one word a cycle. Zero keys and bad
// sizes skip the remainder unit and are answered as the back end picks up the job. The
// front end takes no new item until the last one is in the queue; the two-entry queue
// lets it work on the next key while probing goes on.
module double_hash_search_insert_core
	import dhsi_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: table_size
	input  logic               cfg_we,
	input  logic [SIZE_W-1:0]  cfg_wdata,
	// Input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [KEY_W-1:0]   s_tdata,   // [63:0] key
	input  logic               s_tuser,   // [0] operation
	// Result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata    // [9:0] slot_index, [12:10] status, [15:13] zero
);

	logic [SIZE_W-1:0]   table_size_q;
	q_ctl_t              q_ctl;
	q_stat_t             q_stat;
	logic                q_push, q_pop;
	job_t                push_job, pop_job;
	logic                init_busy;
	logic [SLOT_W-1:0]   out_slot;
	logic [STATUS_W-1:0] out_status;

	assign q_ctl = '{push: q_push, pop: q_pop};

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	dhsi_front #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_key     (s_tdata),
		.table_size (table_size_q),
		.hold       (init_busy),
		.q_full     (q_stat.full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	dhsi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wr_job (push_job),
		.rd_job (pop_job),
		.stat   (q_stat)
	);

	dhsi_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_stat.empty),
		.q_pop      (q_pop),
		.q_job      (pop_job),
		.init_busy  (init_busy),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_slot   (out_slot),
		.out_status (out_status)
	);

	assign m_tdata = {3'b000, out_status, out_slot};

`ifndef SYNTHESIS
	// No item is taken while the reset sweep runs
	a_init_hold: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !s_tready)
		else $error("input accepted during reset sweep");

	// The front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.push |-> !q_stat.full)
		else $error("job queue overflow");

	// Status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_status <= ST_CLEARED))
		else $error("undefined result status");

	// When table_size is at most 1024, a found or inserted slot lies inside the table
	a_slot_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_status == ST_FOUND || out_status == ST_INSERTED)
			&& (table_size_q <= SIZE_W'(1024)))
		|-> ({1'b0, out_slot} < table_size_q))
		else $error("reported slot outside the table");
`endif

endmodule

/* verif/tb_double_hash_search_insert_core.sv */
// Self-checking testbench for the double-hashing search-and-insert key table core.
`timescale 1ns / 100ps

module tb_double_hash_search_insert_core;
	import dhsi_pkg::*;

	localparam int STORE_DEPTH  = 1024;
	localparam int ITEM_TARGET  = 1850;   // total lookups and clears to send
	localparam int STALL_LIMIT  = 12000;  // cycles without any transfer before giving up
	localparam int CFG_SETTLE   = 4;      // quiet cycles before a size write
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} lookup_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [SIZE_W-1:0]  cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [KEY_W-1:0]   s_tdata;   // [63:0] key
	logic               s_tuser;   // [0] operation
	logic               m_tvalid;
	logic               m_tready;
	logic [15:0]        m_tdata;   // [9:0] slot_index, [12:10] status, [15:13] zero

	// Shadow copy of the table and its size register
	logic [KEY_W-1:0]   shadow_keys [STORE_DEPTH];
	logic [SIZE_W-1:0]  shadow_size;
	lookup_result_t     pending_results [$];

	int unsigned        source_gap_max = 19;
	int unsigned        sink_gap_max   = 19;
	int unsigned        items_sent     = 0;
	int unsigned        error_count    = 0;
	int unsigned        idle_cycles    = 0;

	always #5 clk = ~clk;

	double_hash_search_insert_core #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Expected outcome of one request; updates the shadow table as the core should
	function automatic lookup_result_t probe_table(input logic op, input logic [KEY_W-1:0] key);
		lookup_result_t   res;
		logic [KEY_W-1:0] code;
		int unsigned      span;
		int unsigned      slot;
		int unsigned      step;
		int unsigned      n;
		res.slot   = '0;
		res.status = ST_FULL;
		if (op == OP_CLEAR) begin
			foreach (shadow_keys[i])
				shadow_keys[i] = '0;
			res.status = ST_CLEARED;
			return res;
		end
		if (key == '0) begin
			res.status = ST_ZERO_KEY;
			return res;
		end
		span = shadow_size;
		// sizes the store cannot hold are reported as full
		if (span < SIZE_MIN || span > STORE_DEPTH)
			return res;
		code = key - 1'b1;
		slot = int'(code % KEY_W'(span));
		step = 1 + int'(code % KEY_W'(span - 1));
		for (n = 0; n < span; n++) begin
			if (shadow_keys[slot] == '0) begin
				shadow_keys[slot] = key;
				res.slot   = SLOT_W'(slot);
				res.status = ST_INSERTED;
				return res;
			end
			if (shadow_keys[slot] == key) begin
				res.slot   = SLOT_W'(slot);
				res.status = ST_FOUND;
				return res;
			end
			slot = (slot + step) % span;
		end
		// probe cycle exhausted
		return res;
	endfunction

	// One request transfer after a random gap
	task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
		int unsigned gap;
		gap = $urandom_range(source_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(probe_table(op, key));
		items_sent++;
	endtask

	// Wait until every outstanding result is back and the core has gone quiet
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_size = value;
	endtask

	// Reset size, insert, hit, widest key, zero key, clear, insert after clear
	task automatic test_reset_and_basic();
		send_request(OP_SEARCH, 64'd1);
		send_request(OP_SEARCH, 64'd1);
		send_request(OP_SEARCH, '1);
		send_request(OP_SEARCH, '0);
		send_request(OP_CLEAR, '1);
		send_request(OP_SEARCH, 64'd1);
	endtask

	// Smallest working size, largest size, and sizes that cannot be probed
	task automatic test_size_limits();
		write_size(SIZE_W'(2));
		send_request(OP_SEARCH, 64'd5);
		send_request(OP_SEARCH, 64'd6);
		send_request(OP_SEARCH, 64'd7);
		write_size(SIZE_W'(STORE_DEPTH));
		send_request(OP_SEARCH, '1);
		send_request(OP_SEARCH, 64'd1025);
		write_size(SIZE_W'(0));
		send_request(OP_SEARCH, 64'd9);
		write_size(SIZE_W'(1));
		send_request(OP_SEARCH, 64'd9);
		write_size('1);
		send_request(OP_SEARCH, '0);
		send_request(OP_SEARCH, 64'd9);
		write_size(SIZE_W'(STORE_DEPTH + 1));
		send_request(OP_CLEAR, 64'd0);
	endtask

	// Full table, including a non-prime size whose probe cycle skips free slots
	task automatic test_table_full();
		write_size(SIZE_W'(4));
		send_request(OP_SEARCH, 64'd2);
		send_request(OP_SEARCH, 64'd4);
		send_request(OP_SEARCH, 64'd8);
		write_size(SIZE_W'(3));
		send_request(OP_SEARCH, 64'd10);
		send_request(OP_SEARCH, 64'd11);
		send_request(OP_SEARCH, 64'd12);
	endtask

	// Shrinking the table keeps stored keys in place
	task automatic test_resize_keeps_keys();
		write_size(SIZE_W'(7));
		send_request(OP_SEARCH, 64'd20);
		send_request(OP_SEARCH, 64'd21);
		write_size(SIZE_W'(5));
		send_request(OP_SEARCH, 64'd20);
		send_request(OP_SEARCH, 64'd21);
	endtask

	// Phases of random size, idling profile and key pool with forced collisions
	task automatic test_random_traffic();
		logic [KEY_W-1:0] key_pool [$];
		logic [KEY_W-1:0] anchor;
		int unsigned      span;
		int unsigned      pool_len;
		int unsigned      burst;
		int unsigned      roll;
		while (items_sent < ITEM_TARGET) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				case ($urandom_range(8))
					0: span = 3;
					1: span = 5;
					2: span = 7;
					3: span = 11;
					4: span = 13;
					5: span = 17;
					6: span = 31;
					7: span = 61;
					default: span = 127;
				endcase
			end else if (roll < 72) begin
				span = $urandom_range(40, 3);
			end else if (roll < 84) begin
				span = $urandom_range(1) ? 251 : 509;
			end else if (roll < 90) begin
				case ($urandom_range(2))
					0: span = 0;
					1: span = 1;
					default: span = $urandom_range(2047, STORE_DEPTH + 1);
				endcase
			end else if (roll < 95) begin
				span = SIZE_RESET;
			end else begin
				span = STORE_DEPTH;
			end
			write_size(SIZE_W'(span));

			case ($urandom_range(3))
				0: begin
					source_gap_max = 0;
					sink_gap_max   = 0;
				end
				1: begin
					source_gap_max = 19;
					sink_gap_max   = 0;
				end
				2: begin
					source_gap_max = 0;
					sink_gap_max   = 19;
				end
				default: begin
					source_gap_max = 19;
					sink_gap_max   = 19;
				end
			endcase

			// pool a bit larger than small tables so they fill up
			key_pool.delete();
			pool_len = (span < 36) ? span + span / 3 + 2 : 48;
			anchor   = {$urandom, $urandom};
			repeat (pool_len) begin
				if ($urandom_range(1))
					key_pool.push_back({$urandom, $urandom});
				else
					key_pool.push_back(anchor + KEY_W'(span) * KEY_W'($urandom_range(64)));
			end

			if ($urandom_range(1))
				send_request(OP_CLEAR, {$urandom, $urandom});
			burst = $urandom_range(60, 10);
			repeat (burst) begin
				roll = $urandom_range(99);
				if (roll < 3)
					send_request(OP_CLEAR, {$urandom, $urandom});
				else if (roll < 6)
					send_request(OP_SEARCH, '0);
				else if (roll < 12)
					send_request(OP_SEARCH, {$urandom, $urandom});
				else
					send_request(OP_SEARCH, key_pool[$urandom_range(key_pool.size() - 1)]);
			end
		end
	endtask

	// Result sink with random back-pressure
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		forever begin
			stall = $urandom_range(sink_gap_max);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Compare each result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: slot_index %0d, status %0d",
					m_tdata[SLOT_W-1:0], m_tdata[SLOT_W+STATUS_W-1:SLOT_W]);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[SLOT_W-1:0] !== want.slot) begin
					$error("slot_index mismatch: expected %0d, got %0d",
						want.slot, m_tdata[SLOT_W-1:0]);
					error_count++;
				end
				if (m_tdata[SLOT_W+STATUS_W-1:SLOT_W] !== want.status) begin
					$error("status mismatch: expected %0d, got %0d",
						want.status, m_tdata[SLOT_W+STATUS_W-1:SLOT_W]);
					error_count++;
				end
				if (m_tdata[15:SLOT_W+STATUS_W] !== '0) begin
					$error("pad mismatch: expected 0, got %0d", m_tdata[15:SLOT_W+STATUS_W]);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tuser     = OP_SEARCH;
		s_tdata     = '0;
		shadow_size = SIZE_RESET;
		foreach (shadow_keys[i])
			shadow_keys[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_and_basic();
		test_size_limits();
		test_table_full();
		test_resize_keeps_keys();
		test_random_traffic();

		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* double_hash_search_insert_core.f */
sv/dhsi_pkg.sv
sv/dhsi_fifo.sv
sv/dhsi_front.sv
sv/dhsi_back.sv
sv/double_hash_search_insert_core.sv
verif/tb_double_hash_search_insert_core.sv
